// ----- sv/blab_pkg.sv -----
package blab_pkg;

   // item opcodes
   localparam logic [1:0] OP_COMPUTE = 2'd0;
   localparam logic [1:0] OP_WR_LIN  = 2'd1;
   localparam logic [1:0] OP_WR_ATT  = 2'd2;

   // blend weight of one, and the matching shift
   localparam logic [8:0] ALPHA_ONE   = 9'd256;
   localparam int         BLEND_SHIFT = 8;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  node_index;
      logic [15:0] node_value;
      logic [15:0] backlight_in;
      logic [8:0]  alpha;
   } blab_req_type;

   typedef struct packed {
      logic [15:0] backlight_out;
      logic [15:0] linear_level;
   } blab_rsp_type;

endpackage

// ----- sv/backlight_lut_attenuate_blend.sv -----
// a compute item moves down the stage registers, linearity nodes to output register, to rsp_valid
// throughput: one item per cycle while rsp_stall is low; each table is a memory with one write and two
// registered read ports, so both nodes of a segment come out of one access
// reset: synchronous, clears only the stage valid bits; both node tables keep
// their contents and read as unknown until written
module backlight_lut_attenuate_blend #(
   parameter int DATA_WIDTH   = 16,
   parameter int SEGMENT_BITS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  blab_pkg::blab_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output blab_pkg::blab_rsp_type rsp_data
);
   import blab_pkg::*;

   localparam int DW    = DATA_WIDTH;
   localparam int FB    = DATA_WIDTH - SEGMENT_BITS;   // fraction bits of a level
   localparam int NODES = (1 << SEGMENT_BITS) + 1;     // nodes per table
   localparam int IW    = SEGMENT_BITS + 1;            // node address width
   localparam int PW    = FB + DW;                     // interpolation product width
   localparam int BW    = DW + 9;                      // blend product width

   // node tables
   logic [DW-1:0] lin_mem [NODES];
   logic [DW-1:0] att_mem [NODES];

   // per-stage advance: a stage loads when it is empty or its contents move on
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

   // stage valid bits; w marks an attenuation write riding down to stage 4
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic w1_ff, w2_ff, w3_ff;

   // input decode
   logic          req_accept;
   logic          idx_ok;
   logic [DW-1:0] level_x;
   logic [IW-1:0] lin_ra;
   logic          lin_we;
   logic          v1_in, w1_in;
   logic [8:0]    alpha1_in;

   // stage 1: linearity nodes
   logic [DW-1:0] lo1_ff, hi1_ff;
   logic [FB-1:0] frac1_ff;
   logic [8:0]    alpha1_ff;
   logic [IW-1:0] idx1_ff;
   logic [DW-1:0] val1_ff;

   // stage 2: linearity slope product
   logic          neg2_in;
   logic [DW-1:0] diff2;
   logic [PW-1:0] prod2_in;
   logic          neg2_ff;
   logic [DW-1:0] base2_ff;
   logic [PW-1:0] prod2_ff;
   logic [8:0]    alpha2_ff;
   logic [IW-1:0] idx2_ff;
   logic [DW-1:0] val2_ff;

   // stage 3: linear level
   logic [DW-1:0] step3;
   logic [DW-1:0] lin3_in;
   logic [DW-1:0] lin3_ff;
   logic [8:0]    alpha3_ff;
   logic [IW-1:0] idx3_ff;
   logic [DW-1:0] val3_ff;

   // stage 4: attenuation nodes
   logic          att_we;
   logic [IW-1:0] att_ra;
   logic [DW-1:0] lo4_ff, hi4_ff;
   logic [FB-1:0] frac4_ff;
   logic [DW-1:0] lin4_ff;
   logic [8:0]    alpha4_ff;

   // stage 5: attenuation slope product
   logic          neg5_in;
   logic [DW-1:0] diff5;
   logic [PW-1:0] prod5_in;
   logic          neg5_ff;
   logic [DW-1:0] base5_ff;
   logic [PW-1:0] prod5_ff;
   logic [DW-1:0] lin5_ff;
   logic [8:0]    alpha5_ff;

   // stage 6: attenuated level
   logic [DW-1:0] step6;
   logic [DW-1:0] att6_in;
   logic [DW-1:0] att6_ff;
   logic [DW-1:0] lin6_ff;
   logic [8:0]    alpha6_ff;

   // stage 7: blend product
   logic          neg7_in;
   logic [DW-1:0] diff7;
   logic [BW-1:0] prod7_in;
   logic          neg7_ff;
   logic [BW-1:0] prod7_ff;
   logic [DW-1:0] lin7_ff;

   // stage 8: output register
   logic [DW-1:0] mag8;
   logic [DW-1:0] res8_in;
   blab_rsp_type  rsp_ff;

   // stall chain, collapsing bubbles
   assign rdy8      = !v8_ff || !rsp_stall;
   assign rdy7      = !v7_ff || rdy8;
   assign rdy6      = !v6_ff || rdy7;
   assign rdy5      = !v5_ff || rdy6;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   assign req_accept = req_valid && !req_stall;

   // input decode: linearity writes land at once, attenuation writes travel
   // with the pipe so they stay ordered against earlier compute items
   always_comb begin
      idx_ok    = (32'(req_data.node_index) < 32'(NODES));
      level_x   = DW'(req_data.backlight_in);
      lin_ra    = IW'(level_x[DW-1:FB]);
      lin_we    = req_accept && (req_data.opcode == OP_WR_LIN) && idx_ok;
      w1_in     = (req_data.opcode == OP_WR_ATT) && idx_ok;
      v1_in     = req_accept && ((req_data.opcode == OP_COMPUTE) || w1_in);
      alpha1_in = (req_data.alpha > ALPHA_ONE) ? ALPHA_ONE : req_data.alpha;
   end

   // linearity table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (lin_we) begin
         lin_mem[IW'(req_data.node_index)] <= DW'(req_data.node_value);
      end
      if (rdy1) begin
         lo1_ff <= lin_mem[lin_ra];
         hi1_ff <= lin_mem[lin_ra + IW'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         frac1_ff  <= level_x[FB-1:0];
         alpha1_ff <= alpha1_in;
         idx1_ff   <= IW'(req_data.node_index);
         val1_ff   <= DW'(req_data.node_value);
         w1_ff     <= w1_in;
      end
   end

   // segment slope as sign and magnitude, then weight by the fraction
   always_comb begin
      neg2_in  = (hi1_ff < lo1_ff);
      diff2    = neg2_in ? (lo1_ff - hi1_ff) : (hi1_ff - lo1_ff);
      prod2_in = PW'(frac1_ff) * PW'(diff2);
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         neg2_ff   <= neg2_in;
         base2_ff  <= lo1_ff;
         prod2_ff  <= prod2_in;
         alpha2_ff <= alpha1_ff;
         idx2_ff   <= idx1_ff;
         val2_ff   <= val1_ff;
         w2_ff     <= w1_ff;
      end
   end

   // falling segment subtracts the magnitude
   always_comb begin
      step3   = DW'(prod2_ff >> FB);
      lin3_in = neg2_ff ? (base2_ff - step3) : (base2_ff + step3);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         lin3_ff   <= lin3_in;
         alpha3_ff <= alpha2_ff;
         idx3_ff   <= idx2_ff;
         val3_ff   <= val2_ff;
         w3_ff     <= w2_ff;
      end
   end

   // attenuation table, addressed by the linear level
   assign att_we = v3_ff && w3_ff && rdy4;
   assign att_ra = IW'(lin3_ff[DW-1:FB]);

   always_ff @(posedge clock) begin
      if (att_we) begin
         att_mem[idx3_ff] <= val3_ff;
      end
      if (rdy4) begin
         lo4_ff <= att_mem[att_ra];
         hi4_ff <= att_mem[att_ra + IW'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         frac4_ff  <= lin3_ff[FB-1:0];
         lin4_ff   <= lin3_ff;
         alpha4_ff <= alpha3_ff;
      end
   end

   always_comb begin
      neg5_in  = (hi4_ff < lo4_ff);
      diff5    = neg5_in ? (lo4_ff - hi4_ff) : (hi4_ff - lo4_ff);
      prod5_in = PW'(frac4_ff) * PW'(diff5);
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         neg5_ff   <= neg5_in;
         base5_ff  <= lo4_ff;
         prod5_ff  <= prod5_in;
         lin5_ff   <= lin4_ff;
         alpha5_ff <= alpha4_ff;
      end
   end

   always_comb begin
      step6   = DW'(prod5_ff >> FB);
      att6_in = neg5_ff ? (base5_ff - step6) : (base5_ff + step6);
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         att6_ff   <= att6_in;
         lin6_ff   <= lin5_ff;
         alpha6_ff <= alpha5_ff;
      end
   end

   // blend distance from linear toward attenuated level, scaled by alpha
   always_comb begin
      neg7_in  = (att6_ff < lin6_ff);
      diff7    = neg7_in ? (lin6_ff - att6_ff) : (att6_ff - lin6_ff);
      prod7_in = BW'(diff7) * BW'(alpha6_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy7) begin
         neg7_ff  <= neg7_in;
         prod7_ff <= prod7_in;
         lin7_ff  <= lin6_ff;
      end
   end

   // alpha is at most one, so the scaled distance fits the level width
   always_comb begin
      mag8    = DW'(prod7_ff >> BLEND_SHIFT);
      res8_in = neg7_ff ? (lin7_ff - mag8) : (lin7_ff + mag8);
   end

   always_ff @(posedge clock) begin
      if (rdy8) begin
         rsp_ff.backlight_out <= 16'(res8_in);
         rsp_ff.linear_level  <= 16'(lin7_ff);
      end
   end

   // valid bits; attenuation writes retire at stage 4
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= v1_in;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff && !w3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
         if (rdy6) begin
            v6_ff <= v5_ff;
         end
         if (rdy7) begin
            v7_ff <= v6_ff;
         end
         if (rdy8) begin
            v8_ff <= v7_ff;
         end
      end
   end

   assign rsp_valid = v8_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- verif/tb_backlight_lut_attenuate_blend.sv -----
module tb_backlight_lut_attenuate_blend;
   timeunit 1ns;
   timeprecision 1ps;

   import blab_pkg::*;

   // opcode the block has no use for, and the node count of each table
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         NODE_COUNT = 33;
   localparam int         PHASE_ITEMS = 155;

   // prediction of every compute item plus the queue of levels still owed
   class blend_scoreboard;
      logic [15:0]  lin_nodes[NODE_COUNT];
      logic [15:0]  att_nodes[NODE_COUNT];
      blab_rsp_type expected_levels[$];
      int           errors;
      int           n_results;
      int           n_writes;
      int           n_ignored;

      // piecewise-linear lookup: top 5 bits pick the segment, low 11 bits weight it
      function logic [15:0] lut_interp(input bit from_att, input logic [15:0] level);
         int          seg;
         logic [10:0] frac;
         logic [15:0] n0;
         logic [15:0] n1;
         logic [26:0] prod;
         seg  = int'(level[15:11]);
         frac = level[10:0];
         n0   = from_att ? att_nodes[seg]     : lin_nodes[seg];
         n1   = from_att ? att_nodes[seg + 1] : lin_nodes[seg + 1];
         // falling segments subtract the magnitude product
         if (n1 >= n0) begin
            prod = frac * (n1 - n0);
            return n0 + prod[26:11];
         end
         prod = frac * (n0 - n1);
         return n0 - prod[26:11];
      endfunction

      // move lin toward att by alpha/256, sign and magnitude
      function logic [15:0] blend_level(input logic [15:0] lin, input logic [15:0] att,
                                        input logic [8:0] alpha);
         logic [8:0]  weight;
         logic [24:0] mag;
         weight = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
         if (att >= lin) begin
            mag = (att - lin) * weight;
            return lin + 16'(mag >> BLEND_SHIFT);
         end
         mag = (lin - att) * weight;
         return lin - 16'(mag >> BLEND_SHIFT);
      endfunction

      function void note_item(input blab_req_type item);
         blab_rsp_type r;
         logic [15:0]  att;
         case (item.opcode) inside
            OP_COMPUTE: begin
               r.linear_level  = lut_interp(1'b0, item.backlight_in);
               att             = lut_interp(1'b1, r.linear_level);
               r.backlight_out = blend_level(r.linear_level, att, item.alpha);
               expected_levels.push_back(r);
            end
            OP_WR_LIN, OP_WR_ATT: begin
               if (item.node_index < NODE_COUNT) begin
                  if (item.opcode == OP_WR_LIN) lin_nodes[item.node_index] = item.node_value;
                  else att_nodes[item.node_index] = item.node_value;
                  n_writes++;
               end else begin
                  n_ignored++;
               end
            end
            default: n_ignored++;
         endcase
      endfunction

      function void check_result(input blab_rsp_type got);
         blab_rsp_type want;
         if (expected_levels.size() == 0) begin
            $error("result with nothing outstanding: backlight_out %0d linear_level %0d",
                   got.backlight_out, got.linear_level);
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         n_results++;
         if (got.backlight_out !== want.backlight_out) begin
            $error("backlight_out expected %0d actual %0d",
                   want.backlight_out, got.backlight_out);
            errors++;
         end
         if (got.linear_level !== want.linear_level) begin
            $error("linear_level expected %0d actual %0d",
                   want.linear_level, got.linear_level);
            errors++;
         end
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   blab_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   blab_rsp_type rsp_data;

   // chance per cycle, in percent, that the sender idles or the receiver stalls
   int send_idle_pct;
   int stall_pct;

   blend_scoreboard sb;

   backlight_lut_attenuate_blend uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // every accepted result goes straight to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("backlight_lut_attenuate_blend: mismatch");
      $finish;
   end

   function automatic blab_req_type mk_item(input logic [1:0] op, input logic [5:0] idx,
                                            input logic [15:0] val, input logic [15:0] level,
                                            input logic [8:0] alpha);
      blab_req_type item;
      item.opcode       = op;
      item.node_index   = idx;
      item.node_value   = val;
      item.backlight_in = level;
      item.alpha        = alpha;
      return item;
   endfunction

   // hold the item until the block takes it; valid stays up into the next call
   task automatic send_item(input blab_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(item);
   endtask

   // sender goes quiet until every owed result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // mostly compute items over live tables, some table rewrites, a little noise
   function automatic blab_req_type random_item();
      blab_req_type item;
      int           pick;
      pick              = $urandom_range(99);
      item.node_index   = 6'($urandom_range(63));
      item.node_value   = 16'($urandom);
      item.backlight_in = 16'($urandom);
      item.alpha        = ($urandom_range(3) == 0) ? 9'($urandom_range(511))
                                                   : 9'($urandom_range(256));
      if (pick < 70) begin
         item.opcode = OP_COMPUTE;
         // land on segment edges now and then
         case ($urandom_range(7))
            0: item.backlight_in[10:0] = '0;
            1: item.backlight_in[10:0] = '1;
            default: ;
         endcase
      end else if (pick < 88) begin
         item.opcode     = ($urandom_range(1) == 0) ? OP_WR_LIN : OP_WR_ATT;
         item.node_index = 6'($urandom_range(NODE_COUNT - 1));
         case ($urandom_range(5))
            0: item.node_value = 16'h0000;
            1: item.node_value = 16'hFFFF;
            default: ;
         endcase
      end else if (pick < 94) begin
         item.opcode = OP_UNUSED;
      end else begin
         item.opcode     = ($urandom_range(1) == 0) ? OP_WR_LIN : OP_WR_ATT;
         item.node_index = 6'($urandom_range(63, NODE_COUNT));
      end
      return item;
   endfunction

   initial begin
      blab_req_type item;
      int           counted;
      int           ph;

      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 0;
      stall_pct     = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill every node first so no compute ever reads an unwritten one:
      // rising linearity ramp, falling attenuation ramp
      for (int i = 0; i < NODE_COUNT; i++) begin
         send_item(mk_item(OP_WR_LIN, 6'(i), (i == 32) ? 16'hFFFF : 16'(i * 2048),
                           16'h0, 9'h0));
         send_item(mk_item(OP_WR_ATT, 6'(i), (i == 32) ? 16'h0000 : 16'(65535 - i * 2048),
                           16'h0, 9'h0));
      end

      // directed: level and alpha extremes, saturating alpha
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'h0000, 9'd0));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'hFFFF, 9'd256));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'h07FF, 9'd128));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'h0800, 9'd255));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'h8000, 9'd257));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'h7FFF, 9'h1FF));
      // writes past the last node are dropped, and must not alias onto low nodes
      send_item(mk_item(OP_WR_LIN, 6'd33, 16'hFFFF, 16'h0, 9'h0));
      send_item(mk_item(OP_WR_ATT, 6'd63, 16'h0000, 16'h0, 9'h0));
      // unused opcode with every field bit set
      send_item(mk_item(OP_UNUSED, 6'h3F, 16'hFFFF, 16'hFFFF, 9'h1FF));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'h0FFF, 9'd256));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'hFFFF, 9'd200));
      // steepest falling segment at the bottom of the linearity table
      send_item(mk_item(OP_WR_LIN, 6'd0, 16'hFFFF, 16'h0, 9'h0));
      send_item(mk_item(OP_WR_LIN, 6'd1, 16'h0000, 16'h0, 9'h0));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'h07FF, 9'd256));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'h0001, 9'd1));
      // steepest rising segment at the top of the attenuation table
      send_item(mk_item(OP_WR_ATT, 6'd31, 16'h0000, 16'h0, 9'h0));
      send_item(mk_item(OP_WR_ATT, 6'd32, 16'hFFFF, 16'h0, 9'h0));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'hFFFF, 9'd256));
      send_item(mk_item(OP_WR_LIN, 6'd2, 16'hFFFF, 16'h0, 9'h0));
      send_item(mk_item(OP_COMPUTE, 6'h0, 16'h0, 16'h1000, 9'd100));
      // compute with the write-only fields all ones
      send_item(mk_item(OP_COMPUTE, 6'h3F, 16'hFFFF, 16'h5555, 9'h1FF));
      drain_results();

      // random phases: no idling, sender idle, receiver stall, both light
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 59; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 59; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            item = random_item();
            send_item(item);
            counted++;
         end
         // quiet sender until the pipeline is empty
         drain_results();
      end

      // let any stray result show up before judging
      stall_pct = 0;
      repeat (16) @(posedge clock);

      $display("covered %0d compute results, %0d node writes, %0d ignored items",
               sb.n_results, sb.n_writes, sb.n_ignored);
      $display("over four idle/stall phases with full-range levels and alpha up to 511");
      if (sb.errors == 0) begin
         $display("backlight_lut_attenuate_blend: match");
      end else begin
         $display("backlight_lut_attenuate_blend: mismatch");
      end
      $finish;
   end

endmodule
